// ===== rtl/nfcdf_pkg.sv =====
// Shared types and constants of the NFC frame deframer.
// No dependencies; used by nfcdf_step, nfc_frame_deframer_core and nfcdf_checker.
package nfcdf_pkg;

   localparam int unsigned MAX_FRAME = 275;

   localparam logic [7:0] BYTE_00  = 8'h00;
   localparam logic [7:0] BYTE_01  = 8'h01;
   localparam logic [7:0] BYTE_55  = 8'h55;
   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] TFI_RST  = 8'hD5;

   localparam int unsigned START_CODE_LEN = 3;   // 00 00 FF written by the consumer
   localparam int unsigned LEN_FIELDS     = 2;   // LEN and LCS bytes
   localparam int unsigned EXT_FIELDS     = 4;   // extended length header
   localparam logic [1:0]  WAKE_ZEROS     = 2'd3;

   // configuration register indexes
   localparam logic CSR_BUFFER_OFFSET = 1'b0;
   localparam logic CSR_EXPECTED_TFI  = 1'b1;

   // result status codes
   localparam logic [2:0] ST_NONE   = 3'd0;
   localparam logic [2:0] ST_STORED = 3'd1;
   localparam logic [2:0] ST_FRAME  = 3'd2;
   localparam logic [2:0] ST_WAKEUP = 3'd3;
   localparam logic [2:0] ST_DROP   = 3'd4;
   localparam logic [2:0] ST_START  = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_DONE    = 3'd1,
      PH_FLOW    = 3'd2,
      PH_PREFIX  = 3'd3,
      PH_EXT     = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] prev_byte;
      logic [7:0] prev2_byte;
      logic [8:0] write_pos;
      logic [8:0] expected_len;
      logic [7:0] running_sum;
      logic [1:0] wakeup_count;
   } state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [8:0] store_index;
      logic [7:0] store_byte;
      logic [8:0] frame_length;
   } result_type;

   localparam state_type STATE_RST = '{
      phase:        PH_IDLE,
      prev_byte:    BYTE_01,
      prev2_byte:   BYTE_00,
      write_pos:    9'd0,
      expected_len: 9'd0,
      running_sum:  8'd0,
      wakeup_count: 2'd0
   };

endpackage

// ===== rtl/nfcdf_step.sv =====
// Per-item next-state and result logic of the deframer (purely combinational).
// Depends on nfcdf_pkg.
module nfcdf_step (
   input  nfcdf_pkg::state_type  cur,
   input  logic [7:0]            rx_byte,
   input  logic                  buffer_offset,
   input  logic [7:0]            expected_tfi,
   output nfcdf_pkg::state_type  nxt,
   output nfcdf_pkg::result_type res
);

   logic [8:0] wp_inc;
   logic [7:0] sum_inc;
   logic [9:0] ext_total;
   logic [7:0] len_sum;
   logic [8:0] start_pos;
   logic       drop;

   assign wp_inc    = cur.write_pos + 9'd1;
   assign sum_inc   = cur.running_sum + rx_byte;
   assign ext_total = {1'b0, cur.expected_len} + {2'b00, cur.prev2_byte};
   assign len_sum   = cur.prev2_byte + cur.prev_byte;
   assign start_pos = {8'd0, buffer_offset} + 9'(nfcdf_pkg::START_CODE_LEN);

   always_comb begin
      nxt  = cur;
      res  = '0;
      drop = 1'b0;
      case (cur.phase)
         nfcdf_pkg::PH_DONE: begin
            nxt.phase        = nfcdf_pkg::PH_IDLE;
            nxt.write_pos    = '0;
            nxt.expected_len = '0;
            nxt.running_sum  = '0;
            nxt.wakeup_count = '0;
         end
         nfcdf_pkg::PH_FLOW: begin
            res.status      = nfcdf_pkg::ST_STORED;
            res.store_index = cur.write_pos;
            res.store_byte  = rx_byte;
            nxt.write_pos   = wp_inc;
            if (wp_inc >= cur.expected_len) begin
               if (cur.prev_byte == nfcdf_pkg::BYTE_FF && rx_byte == nfcdf_pkg::BYTE_FF) begin
                  nxt.expected_len = cur.expected_len + 9'(nfcdf_pkg::EXT_FIELDS);
                  nxt.phase        = nfcdf_pkg::PH_EXT;
               end else if ((cur.prev_byte == nfcdf_pkg::BYTE_FF &&
                             rx_byte == nfcdf_pkg::BYTE_00) ||
                            (cur.prev_byte == nfcdf_pkg::BYTE_00 &&
                             rx_byte == nfcdf_pkg::BYTE_FF)) begin
                  // ack / nack control frame
                  res.status       = nfcdf_pkg::ST_FRAME;
                  res.frame_length = wp_inc;
                  nxt.phase        = nfcdf_pkg::PH_DONE;
               end else begin
                  nxt.expected_len = cur.expected_len + 9'd1;
                  nxt.phase        = nfcdf_pkg::PH_PREFIX;
               end
            end
         end
         nfcdf_pkg::PH_PREFIX: begin
            res.status      = nfcdf_pkg::ST_STORED;
            res.store_index = cur.write_pos;
            res.store_byte  = rx_byte;
            nxt.write_pos   = wp_inc;
            if (wp_inc >= cur.expected_len) begin
               if (cur.prev2_byte == nfcdf_pkg::BYTE_01 && cur.prev_byte == nfcdf_pkg::BYTE_FF) begin
                  // short error frame: no identifier check
                  nxt.expected_len = cur.expected_len + 9'd1;
                  nxt.running_sum  = rx_byte;
                  nxt.phase        = nfcdf_pkg::PH_PAYLOAD;
               end else if (len_sum == 8'd0) begin
                  if (ext_total > 10'(nfcdf_pkg::MAX_FRAME)) begin
                     drop = 1'b1;
                  end else if (rx_byte == expected_tfi) begin
                     nxt.expected_len = ext_total[8:0];
                     nxt.running_sum  = expected_tfi;
                     nxt.phase        = nfcdf_pkg::PH_PAYLOAD;
                  end else begin
                     drop = 1'b1;
                  end
               end else begin
                  drop = 1'b1;
               end
            end
         end
         nfcdf_pkg::PH_EXT: begin
            drop = 1'b1;
         end
         nfcdf_pkg::PH_PAYLOAD: begin
            res.status      = nfcdf_pkg::ST_STORED;
            res.store_index = cur.write_pos;
            res.store_byte  = rx_byte;
            nxt.write_pos   = wp_inc;
            nxt.running_sum = sum_inc;
            if (wp_inc >= cur.expected_len) begin
               if (sum_inc != 8'd0) begin
                  drop = 1'b1;
               end else begin
                  res.status       = nfcdf_pkg::ST_FRAME;
                  res.frame_length = wp_inc;
                  nxt.phase        = nfcdf_pkg::PH_DONE;
               end
            end
         end
         default: begin
            // idle hunt; unused phase codes land here too
            nxt.phase = nfcdf_pkg::PH_IDLE;
            if (rx_byte == nfcdf_pkg::BYTE_FF && cur.prev_byte == nfcdf_pkg::BYTE_00) begin
               nxt.wakeup_count = '0;
               nxt.write_pos    = start_pos;
               nxt.expected_len = start_pos + 9'(nfcdf_pkg::LEN_FIELDS);
               res.status       = nfcdf_pkg::ST_START;
               res.store_index  = {8'd0, buffer_offset};
               nxt.phase        = nfcdf_pkg::PH_FLOW;
            end else if (rx_byte == nfcdf_pkg::BYTE_55 && cur.prev_byte == nfcdf_pkg::BYTE_55) begin
               nxt.wakeup_count = nfcdf_pkg::WAKE_ZEROS;
            end else if (cur.wakeup_count != 2'd0) begin
               if (rx_byte != nfcdf_pkg::BYTE_00) begin
                  nxt.wakeup_count = '0;
               end else begin
                  nxt.wakeup_count = cur.wakeup_count - 2'd1;
                  if (cur.wakeup_count == 2'd1) begin
                     res.status = nfcdf_pkg::ST_WAKEUP;
                  end
               end
            end
         end
      endcase

      if (drop) begin
         nxt.phase        = nfcdf_pkg::PH_IDLE;
         nxt.write_pos    = '0;
         nxt.expected_len = '0;
         nxt.running_sum  = '0;
         nxt.wakeup_count = '0;
         res              = '0;
         res.status       = nfcdf_pkg::ST_DROP;
      end

      nxt.prev2_byte = cur.prev_byte;
      nxt.prev_byte  = rx_byte;
   end

endmodule

// ===== rtl/nfc_frame_deframer_core.sv =====
// Top level of the NFC frame deframer: input register, state, result register.
// Depends on nfcdf_pkg and nfcdf_step.
//
//  channel | direction | payload
//  req_    | in        | tdata[7:0] rx_byte
//  rsp_    | out       | tuser[2:0] status; tdata store_index, store_byte, frame_length
//  csr_    | in        | index 0 buffer_offset, index 1 expected_tfi
//
// One item per cycle while rsp_tready is high; items pass input, then result register.
// Deframer state updates in the same cycle the result is registered, so items chain freely.
// A stalled result holds the result register; the input register fills, then req_tready drops.
// Synchronous reset clears both valid flags; state and CSRs take their reset values.
module nfc_frame_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [8:0] store_index, [16:9] store_byte,
                                     // [25:17] frame_length, [31:26] zero
   output logic [2:0]  rsp_tuser,    // [2:0] status
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   nfcdf_pkg::result_type out_res_ff;
   nfcdf_pkg::state_type  state_ff, state_in;
   nfcdf_pkg::result_type step_res;
   logic                 offset_ff;
   logic [7:0]           tfi_ff;
   logic                 advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   nfcdf_step u_step (
      .cur           (state_ff),
      .rx_byte       (in_byte_ff),
      .buffer_offset (offset_ff),
      .expected_tfi  (tfi_ff),
      .nxt           (state_in),
      .res           (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= nfcdf_pkg::STATE_RST;
         offset_ff    <= 1'b0;
         tfi_ff       <= nfcdf_pkg::TFI_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               nfcdf_pkg::CSR_BUFFER_OFFSET: offset_ff <= csr_wdata[0];
               nfcdf_pkg::CSR_EXPECTED_TFI:  tfi_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.status;
   assign rsp_tdata  = {6'd0, out_res_ff.frame_length, out_res_ff.store_byte,
                        out_res_ff.store_index};

endmodule

// ===== rtl/nfcdf_checker.sv =====
// Port-level checks of the deframer, bound to nfc_frame_deframer_core.
// Depends on nfcdf_pkg.
module nfcdf_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= nfcdf_pkg::ST_START)
      else $error("status code out of range");

   a_empty_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == nfcdf_pkg::ST_DROP || rsp_tuser == nfcdf_pkg::ST_NONE ||
                     rsp_tuser == nfcdf_pkg::ST_WAKEUP) |-> rsp_tdata == 32'd0)
      else $error("nonzero payload on drop, wakeup or none");

   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == nfcdf_pkg::ST_FRAME |->
         rsp_tdata[25:17] == rsp_tdata[8:0] + 9'd1)
      else $error("frame length does not follow last index");

   a_len_only_on_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nfcdf_pkg::ST_FRAME |-> rsp_tdata[25:17] == 9'd0)
      else $error("frame length outside frame completion");

endmodule

bind nfc_frame_deframer_core nfcdf_port_checks u_nfcdf_port_checks (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
